>>> rtl/mbrm_pkg.sv
package mbrm_pkg;

   // Geometry of the ring and of the sample memory.
   localparam int MAX_BUFFERS = 8;
   localparam int MEM_WORDS   = 1024;
   localparam int WORD_BITS   = 16;
   localparam int MIN_BUFFERS = 2 + 1;

   localparam int IDX_W  = $clog2(MAX_BUFFERS);
   localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
   localparam int ADDR_W = $clog2(MEM_WORDS);

   // Fixed field widths of the ports.
   localparam int NB_W   = 4;
   localparam int BW_W   = 11;
   localparam int DATA_W = 16;
   localparam int CSR_W  = 11;

   localparam logic [NB_W-1:0] RESET_NUM_BUFFERS  = NB_W'(3);
   localparam logic [BW_W-1:0] RESET_BUFFER_WORDS = BW_W'(256);

   typedef enum logic [1:0] {
      KIND_WRITE   = 2'd0,
      KIND_READ    = 2'd1,
      KIND_FINISH  = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_NUM_BUFFERS  = 1'b0,
      CSR_BUFFER_WORDS = 1'b1
   } csr_index_type;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [BW_W-1:0]      count_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type addr;
      word_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic ok;
      logic is_read;
   } result_type;

   // Number of buffers the ring is laid out with: the register clamped to the legal range.
   function automatic logic [CNT_W-1:0] ring_count(input logic [NB_W-1:0] nb);
      logic [CNT_W-1:0] n;
      if (nb < NB_W'(MIN_BUFFERS)) begin
         n = CNT_W'(MIN_BUFFERS);
      end else if (nb > NB_W'(MAX_BUFFERS)) begin
         n = CNT_W'(MAX_BUFFERS);
      end else begin
         n = CNT_W'(nb);
      end
      return n;
   endfunction

   function automatic idx_type next_buffer(input idx_type i, input logic [CNT_W-1:0] ring);
      logic [CNT_W-1:0] n;
      n = CNT_W'(i) + CNT_W'(1);
      return (n >= ring) ? idx_type'(0) : idx_type'(n);
   endfunction

endpackage

>>> rtl/mbrm_store.sv
module mbrm_store (
   input  logic                  clock,
   input  mbrm_pkg::mem_req_type mem_req,
   output mbrm_pkg::word_type    rd_data
);
   import mbrm_pkg::*;

   word_type store_ff [MEM_WORDS];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_ff[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mbrm_ctrl.sv
module mbrm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  mbrm_pkg::kind_type        kind,
   input  logic [15:0]               write_data,
   input  logic [mbrm_pkg::NB_W-1:0] num_buffers,
   input  mbrm_pkg::count_type       buffer_words,
   output mbrm_pkg::mem_req_type     mem_req,
   output mbrm_pkg::result_type      result
);
   import mbrm_pkg::*;

   count_type              fill_ff [MAX_BUFFERS];
   count_type              fill_in [MAX_BUFFERS];
   logic [MAX_BUFFERS-1:0] wr_hold_ff, wr_hold_in;
   logic [MAX_BUFFERS-1:0] rd_hold_ff, rd_hold_in;
   idx_type                wr_idx_ff, wr_idx_in;
   idx_type                rd_idx_ff, rd_idx_in;
   count_type              rd_off_ff, rd_off_in;

   logic [CNT_W-1:0]       ring;
   logic [NB_W+BW_W-1:0]   total_words;
   logic                   geo_ok;
   logic [MAX_BUFFERS-1:0] full_vec, exh_vec, empty_vec;
   idx_type                wr_nx, rd_nx, wr_tgt, rd_tgt, sel_buf;
   logic                   wr_move, rd_move;
   count_type              sel_word, wr_fill;
   logic [IDX_W+BW_W:0]    addr_sum;

   assign ring        = ring_count(num_buffers);
   assign total_words = (NB_W+BW_W)'(num_buffers) * (NB_W+BW_W)'(buffer_words);
   assign geo_ok      = (num_buffers >= NB_W'(MIN_BUFFERS)) &&
                        (num_buffers <= NB_W'(MAX_BUFFERS)) &&
                        (buffer_words != '0) &&
                        (total_words <= (NB_W+BW_W)'(MEM_WORDS));

   // Per-buffer status, so that the ring logic only picks single bits.
   always_comb begin
      for (int i = 0; i < MAX_BUFFERS; i++) begin
         full_vec[i]  = fill_ff[i] >= buffer_words;
         exh_vec[i]   = rd_off_ff >= fill_ff[i];
         empty_vec[i] = fill_ff[i] == '0;
      end
   end

   assign wr_nx   = next_buffer(wr_idx_ff, ring);
   assign rd_nx   = next_buffer(rd_idx_ff, ring);
   assign wr_move = full_vec[wr_idx_ff];
   assign rd_move = exh_vec[rd_idx_ff];
   assign wr_tgt  = wr_move ? wr_nx : wr_idx_ff;
   assign rd_tgt  = rd_move ? rd_nx : rd_idx_ff;
   assign wr_fill = fill_ff[wr_tgt];

   assign sel_buf  = (kind == KIND_READ) ? rd_tgt : wr_tgt;
   assign sel_word = (kind == KIND_READ) ? (rd_move ? '0 : rd_off_ff) : wr_fill;
   // The address wraps round the memory when the geometry was changed without a restart.
   assign addr_sum = (IDX_W+BW_W+1)'(sel_buf) * (IDX_W+BW_W+1)'(buffer_words) +
                     (IDX_W+BW_W+1)'(sel_word);

   always_comb begin
      fill_in    = fill_ff;
      wr_hold_in = wr_hold_ff;
      rd_hold_in = rd_hold_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      rd_off_in  = rd_off_ff;
      mem_req.wr_en   = 1'b0;
      mem_req.rd_en   = 1'b0;
      mem_req.addr    = addr_sum[ADDR_W-1:0];
      mem_req.wdata   = WORD_BITS'(write_data);
      result.ok       = 1'b1;
      result.is_read  = 1'b0;
      case (kind)
         KIND_WRITE: begin
            if (!geo_ok || !wr_hold_ff[wr_idx_ff]) begin
               result.ok = 1'b0;
            end else if (wr_move && rd_hold_ff[wr_nx]) begin
               result.ok = 1'b0;
            end else begin
               if (wr_move) begin
                  wr_hold_in[wr_idx_ff] = 1'b0;
                  wr_hold_in[wr_nx]     = 1'b1;
                  wr_idx_in             = wr_nx;
               end
               if (wr_move && full_vec[wr_nx]) begin
                  result.ok = 1'b0;
               end else begin
                  mem_req.wr_en   = go;
                  fill_in[wr_tgt] = wr_fill + BW_W'(1);
               end
            end
         end
         KIND_READ: begin
            result.is_read = 1'b1;
            if (!geo_ok) begin
               result.ok = 1'b0;
            end else if (rd_move && wr_hold_ff[rd_nx]) begin
               result.ok = 1'b0;
            end else begin
               if (rd_move) begin
                  fill_in[rd_idx_ff]    = '0;
                  rd_hold_in[rd_idx_ff] = 1'b0;
                  rd_hold_in[rd_nx]     = 1'b1;
                  rd_idx_in             = rd_nx;
                  rd_off_in             = '0;
               end
               if (rd_move && empty_vec[rd_nx]) begin
                  result.ok = 1'b0;
               end else begin
                  mem_req.rd_en = go;
                  rd_off_in     = sel_word + BW_W'(1);
               end
            end
         end
         KIND_FINISH: begin
            wr_hold_in[wr_idx_ff] = 1'b0;
         end
         KIND_RESTART: begin
            for (int i = 0; i < MAX_BUFFERS; i++) begin
               fill_in[i] = '0;
            end
            wr_hold_in = '0;
            rd_hold_in = '0;
            wr_hold_in[0] = 1'b1;
            rd_idx_in  = IDX_W'(ring - CNT_W'(1));
            rd_hold_in[IDX_W'(ring - CNT_W'(1))] = 1'b1;
            wr_idx_in  = '0;
            rd_off_in  = '0;
         end
         default: begin
            result.ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BUFFERS; i++) begin
            fill_ff[i] <= '0;
         end
         wr_hold_ff    <= MAX_BUFFERS'(1);
         rd_hold_ff    <= MAX_BUFFERS'(1) << (RESET_NUM_BUFFERS - NB_W'(1));
         wr_idx_ff     <= '0;
         rd_idx_ff     <= IDX_W'(RESET_NUM_BUFFERS - NB_W'(1));
         rd_off_ff     <= '0;
      end else if (go) begin
         fill_ff    <= fill_in;
         wr_hold_ff <= wr_hold_in;
         rd_hold_ff <= rd_hold_in;
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         rd_off_ff  <= rd_off_in;
      end
   end

   // The reader always holds exactly one buffer, the one it points at.
   a_reader_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(rd_hold_ff)) else $error("reader holds other than one buffer");

   a_reader_at_index: assert property (@(posedge clock) disable iff (reset)
      rd_hold_ff[rd_idx_ff]) else $error("reader does not hold its own buffer");

   // The writer holds at most its own buffer.
   a_writer_at_index: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_hold_ff) &&
      ((wr_hold_ff & ~(MAX_BUFFERS'(1) << wr_idx_ff)) == '0))
      else $error("writer holds a buffer other than its own");

   a_no_write_after_finish: assert property (@(posedge clock) disable iff (reset)
      go && (kind == KIND_FINISH) |=> (wr_hold_ff == '0))
      else $error("writer still holds a buffer after finish");

   a_restart_layout: assert property (@(posedge clock) disable iff (reset)
      go && (kind == KIND_RESTART) |=>
      (wr_idx_ff == '0) && (rd_off_ff == '0) && (wr_hold_ff == MAX_BUFFERS'(1)))
      else $error("restart did not return to the initial layout");

endmodule

>>> rtl/multi_buffer_ring_manager.sv
// Ring of equal buffers kept in one sample memory, for streaming samples from a
// producer to a consumer with several buffers in flight.
// Request channel (req_valid, req_stall, req_kind, req_write_data): one operation
// per request - write a sample, read a sample, finish writing, or restart the ring.
// Response channel (rsp_valid, rsp_stall, rsp_ok, rsp_read_data): exactly one
// response per request, in order; rsp_read_data is zero unless a read succeeded.
// The response is shown in the cycle after the request is taken. A request can
// be taken in every cycle while req_stall is low; the ring flags, counts and the
// memory port are updated in that same cycle, and a read's memory word is
// registered on its way to the response.
// csr_wr_en/csr_index/csr_wr_data write the buffer count (index 0) and the words
// per buffer (index 1); write them only while no request is outstanding, and
// issue a restart after changing the buffer count.
// Reset returns the registers to three buffers of 256 words and the ring to its
// initial layout; memory contents are not cleared and no clearing pass is needed.
// While a response is held by rsp_stall, req_stall is raised so that no further
// request is taken until the held response has gone.
module multi_buffer_ring_manager (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_kind,
   input  logic [15:0]                 req_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_ok,
   output logic [15:0]                 rsp_read_data,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [mbrm_pkg::CSR_W-1:0]  csr_wr_data
);
   import mbrm_pkg::*;

   logic [NB_W-1:0] num_buffers_ff;
   count_type       buffer_words_ff;
   logic            rsp_valid_ff;
   logic            ok_ff;
   logic            rd_ok_ff;
   logic            go;
   mem_req_type     mem_req;
   result_type      result;
   word_type        rd_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign go        = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_buffers_ff  <= RESET_NUM_BUFFERS;
         buffer_words_ff <= RESET_BUFFER_WORDS;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_NUM_BUFFERS:  num_buffers_ff  <= csr_wr_data[NB_W-1:0];
            CSR_BUFFER_WORDS: buffer_words_ff <= csr_wr_data[BW_W-1:0];
            default:          num_buffers_ff  <= num_buffers_ff;
         endcase
      end
   end

   mbrm_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .kind         (kind_type'(req_kind)),
      .write_data   (req_write_data),
      .num_buffers  (num_buffers_ff),
      .buffer_words (buffer_words_ff),
      .mem_req      (mem_req),
      .result       (result)
   );

   mbrm_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ok_ff    <= result.ok;
         rd_ok_ff <= result.ok && result.is_read;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_read_data = rd_ok_ff ? DATA_W'(rd_data) : '0;

endmodule
